// ===== rtl/core/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg: shared definitions of the chained hash map
// Operation and status codes, sizing constants and controller state types.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int MAX_BUCKETS_DEF  = 32;
    localparam int POOL_ENTRIES_DEF = 64;
    localparam int CFG_W            = 6;
    localparam logic [CFG_W-1:0] RESET_BUCKETS = 6'd20;
    localparam int KEY_W            = 32;
    localparam int DIV_BITS         = 4;   // dividend bits consumed per cycle

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_SEARCH = 2'd1,
        FN_DELETE = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_FND  = 2'd1,
        ST_FULL     = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } t_fr_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HEAD,
        BK_RD,
        BK_CMP,
        BK_HIT,
        BK_MISS
    } t_bk_state;

endpackage

// ===== rtl/core/chm_if.sv =====
// ----------------------------------------------------------------------------
// chm_req_if / chm_rsp_if: request and response channels
// Valid/ready channels carrying one operation or one result per beat.
// ----------------------------------------------------------------------------
interface chm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic signed [31:0] key;
    logic signed [31:0] value;

    modport source (output valid, func, key, value, input ready);
    modport sink   (input valid, func, key, value, output ready);
endinterface

interface chm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] read_value;

    modport source (output valid, status, read_value, input ready);
    modport sink   (input valid, status, read_value, output ready);
endinterface

// ===== rtl/core/chm_front.sv =====
// ----------------------------------------------------------------------------
// chm_front: request intake and bucket hashing
// Takes a request beat, reduces the signed key modulo the bucket count with a
// radix-16 remainder unit (no-ops skip it), then pushes the job into the queue.
// ----------------------------------------------------------------------------
module chm_front #(
    parameter int MAX_BUCKETS = chm_pkg::MAX_BUCKETS_DEF,
    parameter int HW          = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    parameter int JOB_W       = 2 + 32 + 32 + HW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [chm_pkg::CFG_W-1:0] i_num_buckets,
    chm_req_if.sink                  i_req,
    output logic                     o_push,
    output logic [JOB_W-1:0]         o_job,
    input  logic                     i_full
);
    localparam int BW    = $clog2(MAX_BUCKETS + 1);
    localparam int STEPS = chm_pkg::KEY_W / chm_pkg::DIV_BITS;
    localparam int CW    = $clog2(STEPS + 1);

    chm_pkg::t_fr_state r_state, n_state;
    logic [1:0]   r_func;
    logic [31:0]  r_key, r_value, r_mag, n_mag;
    logic         r_neg;
    logic [BW:0]  r_rem, n_rem;
    logic [CW-1:0] r_cnt;
    logic [BW-1:0] r_mod;
    logic [HW-1:0] w_bucket;
    logic [BW-1:0] w_mod;

    // clamp the configured modulus into 1..MAX_BUCKETS
    always_comb begin
        if (i_num_buckets == '0) begin
            w_mod = BW'(1);
        end else if (int'(i_num_buckets) > MAX_BUCKETS) begin
            w_mod = BW'(MAX_BUCKETS);
        end else begin
            w_mod = BW'(i_num_buckets);
        end
    end

    // remainder step: four restoring compare-subtracts on a narrow value
    always_comb begin
        logic [BW:0] t;
        t = r_rem;
        for (int i = 0; i < chm_pkg::DIV_BITS; i++) begin
            t = {t[BW-1:0], r_mag[31-i]};
            if (t >= {1'b0, r_mod}) begin
                t = t - {1'b0, r_mod};
            end
        end
        n_rem = t;
        n_mag = {r_mag[31-chm_pkg::DIV_BITS:0], {chm_pkg::DIV_BITS{1'b0}}};
    end

    // non-negative remainder for negative keys
    always_comb begin
        logic [BW-1:0] rr;
        rr = r_rem[BW-1:0];
        if (r_neg && rr != '0) begin
            w_bucket = HW'(r_mod - rr);
        end else begin
            w_bucket = HW'(rr);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chm_pkg::FR_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.func == chm_pkg::FN_NOP) ? chm_pkg::FR_PUSH
                                                              : chm_pkg::FR_DIV;
                end
            end
            chm_pkg::FR_DIV: begin
                if (r_cnt == CW'(STEPS - 1)) begin
                    n_state = chm_pkg::FR_PUSH;
                end
            end
            chm_pkg::FR_PUSH: begin
                if (!i_full) begin
                    n_state = chm_pkg::FR_IDLE;
                end
            end
            default: n_state = chm_pkg::FR_IDLE;
        endcase
    end

    assign i_req.ready = (r_state == chm_pkg::FR_IDLE);
    assign o_push      = (r_state == chm_pkg::FR_PUSH) && !i_full;
    assign o_job       = {r_func, r_key, r_value, w_bucket};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chm_pkg::FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == chm_pkg::FR_IDLE && i_req.valid) begin
            r_func  <= i_req.func;
            r_key   <= i_req.key;
            r_value <= i_req.value;
            r_neg   <= i_req.key[31];
            r_mag   <= i_req.key[31] ? (32'd0 - i_req.key) : i_req.key;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_mod   <= w_mod;
        end else if (r_state == chm_pkg::FR_DIV) begin
            r_rem <= n_rem;
            r_mag <= n_mag;
            r_cnt <= r_cnt + CW'(1);
        end
    end
endmodule

// ===== rtl/core/chm_queue.sv =====
// ----------------------------------------------------------------------------
// chm_queue: two-entry job queue
// Decouples hashing from the chain walker so each side stalls on its own.
// ----------------------------------------------------------------------------
module chm_queue #(
    parameter int JOB_W = 70
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [JOB_W-1:0] i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [JOB_W-1:0] o_job
);
    logic [JOB_W-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule

// ===== rtl/core/chm_back.sv =====
// ----------------------------------------------------------------------------
// chm_back: chain walker and table update
// Reads the bucket head, walks the chain through a read and a compare state
// per entry, then updates, links or unlinks and loads the response register.
// ----------------------------------------------------------------------------
module chm_back #(
    parameter int MAX_BUCKETS  = chm_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF,
    parameter int HW           = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    parameter int JOB_W        = 2 + 32 + 32 + HW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [JOB_W-1:0] i_job,
    output logic             o_pop,
    chm_rsp_if.source        o_rsp
);
    localparam int PW = $clog2(POOL_ENTRIES + 1);
    localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam logic [PW-1:0] NULL_LINK = PW'(POOL_ENTRIES);

    // storage
    logic [PW-1:0] r_head_mem [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] r_head_vld;
    logic [31:0]   r_key_mem  [POOL_ENTRIES];
    logic [31:0]   r_val_mem  [POOL_ENTRIES];
    logic [PW-1:0] r_next_mem [POOL_ENTRIES];
    logic [POOL_ENTRIES-1:0] r_free;

    chm_pkg::t_bk_state r_state, n_state;
    logic [1:0]    r_func;
    logic [31:0]   r_key, r_value;
    logic [HW-1:0] r_bucket;
    logic [PW-1:0] r_head_q, r_head, r_cur, r_prev, r_steps, r_next_q;
    logic [31:0]   r_ekey_q, r_eval_q;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [31:0]   r_out_rdata;

    logic          w_out_free, w_load;
    logic [1:0]    w_status;
    logic [31:0]   w_rdata;
    logic          w_head_we, w_key_we, w_val_we, w_next_we, w_free_set, w_free_clr;
    logic [PW-1:0] w_head_wd, w_next_wd, w_slot;
    logic [IW-1:0] w_val_wa, w_next_wa;
    logic [HW-1:0] w_job_bucket;

    assign w_job_bucket = i_job[HW-1:0];
    assign w_out_free   = !r_out_valid || o_rsp.ready;
    assign o_pop        = (r_state == chm_pkg::BK_IDLE) && i_valid;

    // lowest free pool entry
    always_comb begin
        w_slot = NULL_LINK;
        for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
            if (r_free[i]) w_slot = PW'(i);
        end
    end

    // walk control and update strobes
    always_comb begin
        n_state    = r_state;
        w_load     = 1'b0;
        w_status   = chm_pkg::ST_OK;
        w_rdata    = '0;
        w_head_we  = 1'b0;
        w_head_wd  = w_slot;
        w_key_we   = 1'b0;
        w_val_we   = 1'b0;
        w_val_wa   = r_cur[IW-1:0];
        w_next_we  = 1'b0;
        w_next_wa  = r_prev[IW-1:0];
        w_next_wd  = r_next_q;
        w_free_set = 1'b0;
        w_free_clr = 1'b0;
        unique case (r_state)
            chm_pkg::BK_IDLE: begin
                if (i_valid) n_state = chm_pkg::BK_HEAD;
            end
            chm_pkg::BK_HEAD: begin
                n_state = (r_func == chm_pkg::FN_NOP) ? chm_pkg::BK_HIT : chm_pkg::BK_RD;
            end
            chm_pkg::BK_RD: begin
                if (r_cur >= NULL_LINK || r_steps == NULL_LINK) begin
                    n_state = chm_pkg::BK_MISS;
                end else begin
                    n_state = chm_pkg::BK_CMP;
                end
            end
            chm_pkg::BK_CMP: begin
                n_state = (r_ekey_q == r_key) ? chm_pkg::BK_HIT : chm_pkg::BK_RD;
            end
            chm_pkg::BK_HIT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = chm_pkg::BK_IDLE;
                    priority case (r_func)
                        chm_pkg::FN_INSERT: w_val_we = 1'b1;
                        chm_pkg::FN_SEARCH: w_rdata  = r_eval_q;
                        chm_pkg::FN_DELETE: begin
                            w_free_set = 1'b1;
                            if (r_prev == NULL_LINK) begin
                                w_head_we = 1'b1;
                                w_head_wd = r_next_q;
                            end else begin
                                w_next_we = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            chm_pkg::BK_MISS: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = chm_pkg::BK_IDLE;
                    if (r_func == chm_pkg::FN_INSERT) begin
                        if (w_slot == NULL_LINK) begin
                            w_status = chm_pkg::ST_FULL;
                        end else begin
                            w_key_we   = 1'b1;
                            w_val_we   = 1'b1;
                            w_val_wa   = w_slot[IW-1:0];
                            w_next_we  = 1'b1;
                            w_next_wa  = w_slot[IW-1:0];
                            w_next_wd  = r_head;
                            w_head_we  = 1'b1;
                            w_free_clr = 1'b1;
                        end
                    end else begin
                        w_status = chm_pkg::ST_NOT_FND;
                    end
                end
            end
            default: n_state = chm_pkg::BK_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chm_pkg::BK_IDLE;
            r_head_vld  <= '0;
            r_free      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_head_we) r_head_vld[r_bucket] <= 1'b1;
            if (w_free_set) r_free[r_cur[IW-1:0]] <= 1'b1;
            if (w_free_clr) r_free[w_slot[IW-1:0]] <= 1'b0;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // job and walk registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            {r_func, r_key, r_value, r_bucket} <= i_job;
        end
        if (r_state == chm_pkg::BK_HEAD) begin
            r_head  <= r_head_vld[r_bucket] ? r_head_q : NULL_LINK;
            r_cur   <= r_head_vld[r_bucket] ? r_head_q : NULL_LINK;
            r_prev  <= NULL_LINK;
            r_steps <= '0;
        end else if (r_state == chm_pkg::BK_CMP && r_ekey_q != r_key) begin
            r_prev  <= r_cur;
            r_cur   <= r_next_q;
            r_steps <= r_steps + PW'(1);
        end
        if (w_load) begin
            r_out_status <= w_status;
            r_out_rdata  <= w_rdata;
        end
    end

    // bucket head memory
    always_ff @(posedge i_clk) begin
        if (w_head_we) r_head_mem[r_bucket] <= w_head_wd;
        r_head_q <= r_head_mem[w_job_bucket];
    end

    // pool memories
    always_ff @(posedge i_clk) begin
        if (w_key_we)  r_key_mem[w_slot[IW-1:0]] <= r_key;
        if (w_val_we)  r_val_mem[w_val_wa] <= r_value;
        if (w_next_we) r_next_mem[w_next_wa] <= w_next_wd;
        r_ekey_q <= r_key_mem[r_cur[IW-1:0]];
        r_eval_q <= r_val_mem[r_cur[IW-1:0]];
        r_next_q <= r_next_mem[r_cur[IW-1:0]];
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.read_value = r_out_rdata;
endmodule

// ===== rtl/core/chained_hash_map_core.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_core: key-value store with separately chained buckets
// Insert/update, search and delete of signed 32-bit keys over a fixed pool.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one operation per beat (func, key, value); o_rsp returns
//   exactly one result per operation (status, read_value), in order.
//   i_cfg_we/i_cfg_wdata set the bucket count; write it only while idle.
// Path, accept to response valid: key hashing in the radix-16 remainder
//   unit (skipped for no-ops), push of the job, pop of it with the bucket
//   head read, take of the head, a read and a compare state per chain
//   entry visited, then update and load of the response register; a miss
//   ends with one more head check that finds the chain end.
// Flow: the hasher takes a new request only once it has pushed the last
//   job; the chain walker handles one job at a time, from pop to response;
//   a 2-entry job queue sits between.
// Reset: synchronous, active low; all buckets empty, whole pool free,
//   bucket count 20. No clearing pass is needed.
// Stall: a held response keeps the walker from finishing the next job; the
//   queue and hasher keep taking requests until the queue fills.
// ----------------------------------------------------------------------------
module chained_hash_map_core #(
    parameter int MAX_BUCKETS  = chm_pkg::MAX_BUCKETS_DEF,
    parameter int POOL_ENTRIES = chm_pkg::POOL_ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [chm_pkg::CFG_W-1:0] i_cfg_wdata,
    chm_req_if.sink                   i_req,
    chm_rsp_if.source                 o_rsp
);
    localparam int HW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int JOB_W = 2 + 32 + 32 + HW;

    logic [chm_pkg::CFG_W-1:0] r_num_buckets;
    logic             w_push, w_full, w_pop, w_qvalid;
    logic [JOB_W-1:0] w_job_in, w_job_out;

    // bucket count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_buckets <= chm_pkg::RESET_BUCKETS;
        end else if (i_cfg_we) begin
            r_num_buckets <= i_cfg_wdata;
        end
    end

    chm_front #(.MAX_BUCKETS(MAX_BUCKETS), .HW(HW), .JOB_W(JOB_W)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_num_buckets (r_num_buckets),
        .i_req         (i_req),
        .o_push        (w_push),
        .o_job         (w_job_in),
        .i_full        (w_full)
    );

    chm_queue #(.JOB_W(JOB_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_job   (w_job_out)
    );

    chm_back #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES),
        .HW           (HW),
        .JOB_W        (JOB_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );
endmodule

// ===== rtl/core/chm_checker.sv =====
// ----------------------------------------------------------------------------
// chm_checker: port-level checks of the hash map core
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module chm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [31:0] i_rsp_read_value
);
    logic [3:0] r_pending;

    // requests accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 4'(i_req_valid && i_req_ready)
                                   - 4'(i_rsp_valid && i_rsp_ready);
        end
    end

    // no response beat without an outstanding request
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_pending != 4'd0)
        else $error("response without pending request");

    // reserved status code never shows
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_status != chm_pkg::ST_RSVD)
        else $error("reserved status");

    // only a successful operation may carry a value
    a_rdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != chm_pkg::ST_OK) |-> i_rsp_read_value == 32'd0)
        else $error("value on failed operation");

    // a stalled response beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_read_value))
        else $error("response dropped or changed under stall");
endmodule

bind chained_hash_map_core chm_checker u_chm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_read_value (o_rsp.read_value)
);
